/* rtl/clt_pkg.sv */
package clt_pkg;

  typedef enum logic [1:0] {
    ST_OUT   = 2'd0,
    ST_ARG   = 2'd1,
    ST_QUOTE = 2'd2
  } scan_t;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_COMMIT  = 2'd2,
    CMD_DISCARD = 2'd3
  } cmd_t;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef struct packed {
    scan_t scan;
    logic  quote_single;
    logic  esc;
  } tok_state_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] chr;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_list_t;

endpackage

/* rtl/clt_decode.sv */
module clt_decode (
  input  logic              op,
  input  logic [7:0]        ch,
  input  logic              win_mode,
  input  clt_pkg::tok_state_t st,
  output clt_pkg::tok_state_t st_nxt,
  output clt_pkg::res_list_t  res
);
  import clt_pkg::*;

  function automatic res_list_t put_res(res_list_t l, cmd_t cmd, logic [7:0] c);
    res_list_t o;
    o = l;
    if (l.n == 2'd0) begin
      o.r0 = '{cmd: cmd, chr: c};
      o.n  = 2'd1;
    end else if (l.n == 2'd1) begin
      o.r1 = '{cmd: cmd, chr: c};
      o.n  = 2'd2;
    end
    return o;
  endfunction

  scan_t scan_eff;
  logic  is_quote;
  logic  is_single;
  logic  is_blank;
  logic  is_bslash;
  logic  literal_esc;

  always_comb begin
    unique case (st.scan)
      ST_ARG:   scan_eff = ST_ARG;
      ST_QUOTE: scan_eff = ST_QUOTE;
      default:  scan_eff = ST_OUT;
    endcase
  end

  assign is_single   = (ch == CH_SQUOTE);
  assign is_quote    = (ch == CH_DQUOTE) || is_single;
  assign is_blank    = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_bslash   = (ch == CH_BSLASH);
  assign literal_esc = st.esc && !win_mode;

  // next state
  always_comb begin
    st_nxt      = st;
    st_nxt.scan = scan_eff;
    if (op) begin
      st_nxt = '{scan: ST_OUT, quote_single: 1'b0, esc: 1'b0};
    end else if (literal_esc) begin
      st_nxt.esc = 1'b0;
    end else begin
      st_nxt.esc = 1'b0;
      if (is_quote) begin
        if (scan_eff == ST_QUOTE) begin
          if (is_single == st.quote_single) st_nxt.scan = ST_ARG;
        end else begin
          st_nxt.scan         = ST_QUOTE;
          st_nxt.quote_single = is_single;
        end
      end else if (is_blank) begin
        if (scan_eff == ST_ARG) st_nxt.scan = ST_OUT;
      end else if (is_bslash) begin
        if (scan_eff == ST_OUT) st_nxt.scan = ST_ARG;
        st_nxt.esc = 1'b1;
      end else begin
        if (scan_eff == ST_OUT) st_nxt.scan = ST_ARG;
      end
    end
  end

  // result commands
  always_comb begin
    res = '0;
    if (op) begin
      if (st.esc && win_mode) res = put_res(res, CMD_APPEND, CH_BSLASH);
      if (st.scan == ST_ARG) begin
        res = put_res(res, CMD_COMMIT, 8'h00);
      end else if (st.scan == ST_QUOTE) begin
        res = put_res(res, CMD_DISCARD, 8'h00);
      end
    end else if (literal_esc) begin
      res = put_res(res, CMD_APPEND, ch);
    end else begin
      if (st.esc && (ch != CH_DQUOTE)) res = put_res(res, CMD_APPEND, CH_BSLASH);
      if (is_quote) begin
        if (scan_eff == ST_QUOTE) begin
          if (is_single != st.quote_single) res = put_res(res, CMD_APPEND, ch);
        end else if (scan_eff == ST_OUT) begin
          res = put_res(res, CMD_BEGIN, 8'h00);
        end
      end else if (is_blank) begin
        if (scan_eff == ST_ARG) begin
          res = put_res(res, CMD_COMMIT, 8'h00);
        end else if (scan_eff == ST_QUOTE) begin
          res = put_res(res, CMD_APPEND, ch);
        end
      end else if (is_bslash) begin
        if (scan_eff == ST_OUT) res = put_res(res, CMD_BEGIN, 8'h00);
      end else begin
        if (scan_eff == ST_OUT) res = put_res(res, CMD_BEGIN, 8'h00);
        res = put_res(res, CMD_APPEND, ch);
      end
    end
  end

endmodule

/* rtl/command_line_tokenizer.sv */
// Shell-style argument tokenizer. One byte is taken per input transaction
// (in_tuser high marks end of string) and each byte is decoded in the cycle
// it is accepted, giving zero, one or two commands (begin, append, commit,
// discard) that enter a four-entry result queue; out_tlast marks the last
// command caused by one input transaction. A new byte is accepted every cycle
// while the queue holds at most two commands, and the queue drains one command
// per cycle while out_tready is high, so the sustained rate is one byte per
// cycle whenever the average number of commands per byte is at most one, and
// otherwise follows the output. cfg_wr_en writes the Windows escape mode bit.
module command_line_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] op (end of string)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] command, [9:2] out_char, [15:10] zero
  output logic        out_tlast
);
  import clt_pkg::*;

  typedef struct packed {
    res_t r;
    logic last;
  } q_entry_t;

  logic       win_mode_r;
  tok_state_t st_r;
  tok_state_t st_nxt;
  res_list_t  res;
  q_entry_t   q_r [4];
  logic [1:0] wr_ptr_r;
  logic [1:0] rd_ptr_r;
  logic [2:0] count_r;
  logic       in_acc;
  logic       out_acc;
  logic [1:0] push_n;
  logic [1:0] wr_ptr_p1;
  q_entry_t   head;

  clt_decode u_decode (
    .op       (in_tuser),
    .ch       (in_tdata),
    .win_mode (win_mode_r),
    .st       (st_r),
    .st_nxt   (st_nxt),
    .res      (res)
  );

  assign in_tready = (count_r <= 3'd2);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign push_n    = in_acc ? res.n : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      win_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{scan: ST_OUT, quote_single: 1'b0, esc: 1'b0};
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= '{r: res.r0, last: (res.n == 2'd1)};
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_p1] <= '{r: res.r1, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n;
      if (out_acc) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r <= count_r + {1'b0, push_n} - {2'b00, out_acc};
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (count_r != 3'd0);
  assign out_tdata  = {6'b000000, head.r.chr, head.r.cmd};
  assign out_tlast  = head.last;

endmodule

/* tb/tok_scoreboard_pkg.sv */
`timescale 1ns / 100ps
package tok_scoreboard_pkg;
  import clt_pkg::*;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] chr;
    logic       last;
  } tok_cmd_t;

  class tok_scoreboard;
    bit       win_mode;
    scan_t    scan;
    bit       quote_single;
    bit       esc_pending;
    tok_cmd_t expected_cmds[$];
    tok_cmd_t step_cmds[2];
    int       step_count;
    int       errors;
    int       items_seen;
    int       cmds_checked;

    function new();
      win_mode     = 1'b0;
      scan         = ST_OUT;
      quote_single = 1'b0;
      esc_pending  = 1'b0;
      step_count   = 0;
      errors       = 0;
      items_seen   = 0;
      cmds_checked = 0;
    endfunction

    function void set_mode(bit m);
      win_mode = m;
    endfunction

    function int outstanding();
      return expected_cmds.size();
    endfunction

    function void emit(cmd_t c, logic [7:0] b);
      if (step_count < 2) begin
        step_cmds[step_count].cmd  = c;
        step_cmds[step_count].chr  = b;
        step_cmds[step_count].last = 1'b0;
        step_count++;
      end
    endfunction

    // one byte with no escape waiting
    function void decode_byte(logic [7:0] c);
      scan_t st;
      bit    single;
      st = (scan == ST_ARG || scan == ST_QUOTE) ? scan : ST_OUT;
      if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        single = (c == CH_SQUOTE);
        if (st == ST_QUOTE) begin
          if (single == quote_single) scan = ST_ARG;
          else emit(CMD_APPEND, c);
        end else begin
          if (st == ST_OUT) emit(CMD_BEGIN, 8'h00);
          scan         = ST_QUOTE;
          quote_single = single;
        end
      end else if (c == CH_SPACE || c == CH_TAB) begin
        if (st == ST_ARG) begin
          emit(CMD_COMMIT, 8'h00);
          scan = ST_OUT;
        end else if (st == ST_QUOTE) begin
          emit(CMD_APPEND, c);
        end
      end else if (c == CH_BSLASH) begin
        if (st == ST_OUT) begin
          emit(CMD_BEGIN, 8'h00);
          scan = ST_ARG;
        end
        esc_pending = 1'b1;
      end else begin
        if (st == ST_OUT) begin
          emit(CMD_BEGIN, 8'h00);
          scan = ST_ARG;
        end
        emit(CMD_APPEND, c);
      end
    endfunction

    function void note_input(bit eos, logic [7:0] c);
      step_count = 0;
      items_seen++;
      if (eos) begin
        if (esc_pending && win_mode) emit(CMD_APPEND, CH_BSLASH);
        if (scan == ST_ARG) emit(CMD_COMMIT, 8'h00);
        else if (scan == ST_QUOTE) emit(CMD_DISCARD, 8'h00);
        scan         = ST_OUT;
        quote_single = 1'b0;
        esc_pending  = 1'b0;
      end else if (esc_pending) begin
        esc_pending = 1'b0;
        if (win_mode) begin
          if (c != CH_DQUOTE) emit(CMD_APPEND, CH_BSLASH);
          decode_byte(c);
        end else begin
          emit(CMD_APPEND, c);
        end
      end else begin
        decode_byte(c);
      end
      for (int i = 0; i < step_count; i++) begin
        step_cmds[i].last = (i == step_count - 1);
        expected_cmds.insert(expected_cmds.size(), step_cmds[i]);
      end
    endfunction

    function void check_result(logic [15:0] data, logic last);
      tok_cmd_t want;
      cmds_checked++;
      if (expected_cmds.size() == 0) begin
        $error("unexpected command %0d char 0x%02h", data[1:0], data[9:2]);
        errors++;
        return;
      end
      want = expected_cmds.pop_front();
      if (data[1:0] !== want.cmd) begin
        $error("command: expected %0d, got %0d", want.cmd, data[1:0]);
        errors++;
      end
      if (data[9:2] !== want.chr) begin
        $error("out_char: expected 0x%02h, got 0x%02h", want.chr, data[9:2]);
        errors++;
      end
      if (data[15:10] !== 6'd0) begin
        $error("pad: expected 0x00, got 0x%02h", data[15:10]);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/command_line_tokenizer_tb.sv */
`timescale 1ns / 100ps
module command_line_tokenizer_tb;
  import clt_pkg::*;
  import tok_scoreboard_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 238;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;
  logic        in_tuser    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  tok_scoreboard tok_sb;
  bit            in_gaps_on    = 1'b1;
  bit            out_stalls_on = 1'b1;
  int            stall_left    = 0;
  int            quiet_cycles  = 0;
  int            mode_writes[2];

  command_line_tokenizer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side backpressure in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (out_stalls_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tok_sb.note_input(in_tuser, in_tdata);
      if (out_tvalid && out_tready) tok_sb.check_result(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_item(bit eos, logic [7:0] c);
    int gap;
    if (in_gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= eos;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(1'b0, c);
  endtask

  task automatic send_eos();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tok_sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tok_sb.set_mode(m);
    mode_writes[m]++;
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 15) return 8'($urandom_range(8'h21, 8'h7E));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_char(int special_pct);
    if ($urandom_range(0, 99) >= special_pct) return word_char();
    case ($urandom_range(0, 4))
      0: return CH_DQUOTE;
      1: return CH_SQUOTE;
      2: return CH_BSLASH;
      3: return CH_SPACE;
      default: return CH_TAB;
    endcase
  endfunction

  function automatic logic [7:0] blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  task automatic send_word();
    logic [7:0] q;
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(1, 5)) send_char(word_char());
        1: begin
          // quoted section, may hold blanks and the other quote kind
          q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
          send_char(q);
          repeat ($urandom_range(0, 5)) send_char(pick_char(35));
          send_char(q);
        end
        2: begin
          send_char(CH_BSLASH);
          send_char(pick_char(60));
        end
        default: send_char(word_char());
      endcase
    end
  endtask

  task automatic send_line();
    if ($urandom_range(0, 4) != 0) begin
      repeat ($urandom_range(0, 4)) begin
        repeat ($urandom_range(0, 2)) send_char(blank());
        send_word();
      end
      repeat ($urandom_range(0, 1)) send_char(blank());
      if ($urandom_range(0, 5) == 0) send_char(CH_BSLASH);
    end else begin
      repeat ($urandom_range(1, 10)) send_char(pick_char(40));
    end
    send_eos();
  endtask

  initial begin
    int phase_end;
    bit m;
    tok_sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(1'b0);
    send_char(CH_SPACE);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_TAB);
    // empty quoted argument
    send_char(CH_DQUOTE);
    send_char(CH_DQUOTE);
    send_char(CH_SPACE);
    send_char(CH_SQUOTE);
    send_char(CH_DQUOTE);
    send_char(CH_TAB);
    send_char(CH_SQUOTE);
    // escaped quote, then trailing escape dropped
    send_char(CH_BSLASH);
    send_char(CH_SQUOTE);
    send_char(CH_BSLASH);
    send_eos();
    // escape opens an argument, unterminated quote discarded
    send_char(CH_BSLASH);
    send_char(CH_SPACE);
    send_char(CH_DQUOTE);
    send_eos();
    // escape pending across a mode change
    send_char(CH_BSLASH);
    settle();
    write_mode(1'b1);
    send_char(8'h71);
    send_char(CH_BSLASH);
    send_char(CH_DQUOTE);
    send_char(CH_BSLASH);
    send_eos();
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      m = (phase == 3) ? 1'($urandom_range(0, 1)) : ~phase[0];
      in_gaps_on    = (phase != 2) && (phase != PHASES - 1);
      out_stalls_on = (phase != 3) && (phase != PHASES - 1);
      write_mode(m);
      phase_end = tok_sb.items_seen + PHASE_ITEMS;
      while (tok_sb.items_seen < phase_end) send_line();
      settle();
    end

    $display("%0d input transactions, %0d commands checked",
             tok_sb.items_seen, tok_sb.cmds_checked);
    $display("escape mode writes: default %0d, windows %0d", mode_writes[0], mode_writes[1]);
    if (tok_sb.errors == 0 && tok_sb.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
